// ----- rtl/core/selq_pkg.sv -----
// Shared types, codes and defaults of the shared/exclusive lock queue.
package selq_pkg;

	localparam int DEF_MAX_OWNERS  = 16;
	localparam int DEF_MAX_WAITERS = 16;
	localparam int DEF_TXN_BITS    = 32;

	localparam int ID_W  = 32;
	localparam int EXP_W = 48;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 88;

	// Lock modes
	localparam logic [1:0] MODE_FREE   = 2'd0;
	localparam logic [1:0] MODE_SHARED = 2'd1;
	localparam logic [1:0] MODE_EXCL   = 2'd2;

	// Commands
	localparam logic CMD_GRAB = 1'b0;
	localparam logic CMD_DROP = 1'b1;

	typedef enum logic [2:0] {
		ST_GRANTED   = 3'd0,
		ST_WAITING   = 3'd1,
		ST_ALREADY   = 3'd2,
		ST_RELEASED  = 3'd3,
		ST_HANDED    = 3'd4,
		ST_NOT_OWNER = 3'd5,
		ST_FULL      = 3'd6
	} status_t;

	// Owner table write-side control
	typedef struct packed {
		logic wr_en;
		logic set_valid;
		logic clr_valid;
	} own_wr_t;

	function automatic logic [EXP_W-1:0] max_exp(input logic [EXP_W-1:0] a,
		input logic [EXP_W-1:0] b);
		max_exp = (a > b) ? a : b;
	endfunction

endpackage

// ----- rtl/core/selq_owner_tbl.sv -----
// Owner table: synchronous memory of owner entries plus per-slot valid flops.
module selq_owner_tbl #(
	parameter int MAX_OWNERS = 16,
	parameter int TXN_BITS   = 32,
	localparam int OIW = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1,
	localparam int TW  = (TXN_BITS < 32) ? TXN_BITS : 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  selq_pkg::own_wr_t     wr,
	input  logic [OIW-1:0]        wr_addr,
	input  logic [TW-1:0]         wr_txn,
	input  logic                  wr_ex,
	input  logic                  rd_en,
	input  logic [OIW-1:0]        rd_addr,
	output logic                  rd_valid,
	output logic [TW-1:0]         rd_txn,
	output logic                  rd_ex
);
	import selq_pkg::*;

	logic [TW:0]           mem_q [MAX_OWNERS];
	logic [MAX_OWNERS-1:0] valid_q;
	logic [TW:0]           rd_data_q;
	logic                  rd_valid_q;

	// Entry storage and registered read
	always_ff @(posedge clk) begin
		if (wr.wr_en) begin
			mem_q[wr_addr] <= {wr_ex, wr_txn};
		end
		if (rd_en) begin
			rd_data_q  <= mem_q[rd_addr];
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	// Valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.set_valid) begin
			valid_q[wr_addr] <= 1'b1;
		end else if (wr.clr_valid) begin
			valid_q[wr_addr] <= 1'b0;
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_txn   = rd_data_q[TW-1:0];
	assign rd_ex    = rd_data_q[TW];

endmodule

// ----- rtl/core/selq_wait_ring.sv -----
// Waiter ring: synchronous memory of queued requests.
module selq_wait_ring #(
	parameter int MAX_WAITERS = 16,
	parameter int TXN_BITS    = 32,
	localparam int WIW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1,
	localparam int TW  = (TXN_BITS < 32) ? TXN_BITS : 32
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [WIW-1:0]             wr_addr,
	input  logic [TW-1:0]              wr_txn,
	input  logic                       wr_ex,
	input  logic [selq_pkg::EXP_W-1:0] wr_exp,
	input  logic                       rd_en,
	input  logic [WIW-1:0]             rd_addr,
	output logic [TW-1:0]              rd_txn,
	output logic                       rd_ex,
	output logic [selq_pkg::EXP_W-1:0] rd_exp
);
	import selq_pkg::*;

	localparam int EW = TW + 1 + EXP_W;

	logic [EW-1:0] mem_q [MAX_WAITERS];
	logic [EW-1:0] rd_data_q;

	// Entry storage and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_exp, wr_ex, wr_txn};
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_txn = rd_data_q[TW-1:0];
	assign rd_ex  = rd_data_q[TW];
	assign rd_exp = rd_data_q[EW-1:TW+1];

endmodule

// ----- rtl/core/shared_exclusive_lock_queue.sv -----
// Shared/exclusive lock with owner table and FIFO of waiters (top level).
// One request at a time. A grab or a drop first scans every owner slot through the
// owner table's single read port; a grab by a requester that owns nothing then scans
// the waiters, and a drop by the last owner hands the lock to the head waiters, with
// one result per grant. Output stalls hold the block.
// Reset (arst_n low) empties owners and waiters, frees the lock, expiry zero.
module shared_exclusive_lock_queue #(
	parameter int MAX_OWNERS  = selq_pkg::DEF_MAX_OWNERS,
	parameter int MAX_WAITERS = selq_pkg::DEF_MAX_WAITERS,
	parameter int TXN_BITS    = selq_pkg::DEF_TXN_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// txn_id[31:0], want_exclusive[32], expiry_time[80:33], zero pad
	input  logic [selq_pkg::IN_DATA_W-1:0]  s_tdata,
	// command[0]
	input  logic [0:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// granted_txn[31:0], hold_mode[33:32], lock_expiry[81:34], zero pad
	output logic [selq_pkg::OUT_DATA_W-1:0] m_tdata,
	// status[2:0]
	output logic [2:0]                      m_tuser,
	output logic                            m_tlast
);
	import selq_pkg::*;

	localparam int OIW = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
	localparam int WIW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int OCW = $clog2(MAX_OWNERS + 1);
	localparam int WCW = $clog2(MAX_WAITERS + 1);
	localparam int TW  = (TXN_BITS < 32) ? TXN_BITS : 32;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_OSCAN = 9'b000000010,
		S_OEVAL = 9'b000000100,
		S_WSCAN = 9'b000001000,
		S_WEVAL = 9'b000010000,
		S_RESP  = 9'b000100000,
		S_HO_RD = 9'b001000000,
		S_HO_PR = 9'b010000000,
		S_EM_RD = 9'b100000000
	} fsm_t;

	fsm_t state_q, state_d;
	logic em_out_q, em_out_d;

	// Request latch
	logic            cmd_q;
	logic [TW-1:0]   t_q;
	logic            ex_q;
	logic [EXP_W-1:0] e_q;

	// Scan state
	logic [OCW-1:0]  oiss_q, oiss_d;
	logic            pv_s1;
	logic [OIW-1:0]  pidx_s1;
	logic            found_q, found_d;
	logic [OIW-1:0]  fidx_q, fidx_d;
	logic            fex_q, fex_d;
	logic            free_ok_q, free_ok_d;
	logic [OIW-1:0]  free_idx_q, free_idx_d;
	logic [WCW-1:0]  wiss_q, wiss_d;
	logic [WIW-1:0]  wptr_q, wptr_d;
	logic            wpv_s1;
	logic [WCW-1:0]  wproc_q, wproc_d;
	logic            wmatch_q, wmatch_d;
	status_t         st_q, st_d;
	logic [OCW-1:0]  n_q, n_d;
	logic [OCW-1:0]  k_q, k_d;
	logic            first_q, first_d;

	// Lock state
	logic [OCW-1:0]   ocount_q, ocount_d;
	logic [WCW-1:0]   wcount_q, wcount_d;
	logic [WIW-1:0]   head_q, head_d;
	logic [1:0]       held_q, held_d;
	logic [EXP_W-1:0] exp_q, exp_d;

	// Output register
	logic             m_valid_q;
	status_t          m_status_q;
	logic [TW-1:0]    m_txn_q;
	logic             m_last_q;
	logic [1:0]       m_hold_q;
	logic [EXP_W-1:0] m_exp_q;
	logic             out_load;
	status_t          out_status;
	logic [TW-1:0]    out_txn;
	logic             out_last;
	logic             out_free;

	// Memory ports
	own_wr_t          o_wr;
	logic [OIW-1:0]   o_wr_addr;
	logic [TW-1:0]    o_wr_txn;
	logic             o_wr_ex;
	logic             o_rd_en;
	logic [OIW-1:0]   o_rd_addr;
	logic             o_rd_valid;
	logic [TW-1:0]    o_rd_txn;
	logic             o_rd_ex;
	logic             w_wr_en;
	logic [WIW-1:0]   w_wr_addr;
	logic [TW-1:0]    w_wr_txn;
	logic             w_wr_ex;
	logic [EXP_W-1:0] w_wr_exp;
	logic             w_rd_en;
	logic [WIW-1:0]   w_rd_addr;
	logic [TW-1:0]    w_rd_txn;
	logic             w_rd_ex;
	logic [EXP_W-1:0] w_rd_exp;

	logic [WCW:0]     tail_sum;
	logic [WIW-1:0]   tail_idx;
	logic [WIW-1:0]   head_dec;
	logic [WIW-1:0]   head_inc;
	logic [WIW-1:0]   wptr_inc;
	logic             in_xfer;
	logic             ho_cont;

	selq_owner_tbl #(
		.MAX_OWNERS(MAX_OWNERS),
		.TXN_BITS  (TXN_BITS)
	) u_owner (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (o_wr),
		.wr_addr (o_wr_addr),
		.wr_txn  (o_wr_txn),
		.wr_ex   (o_wr_ex),
		.rd_en   (o_rd_en),
		.rd_addr (o_rd_addr),
		.rd_valid(o_rd_valid),
		.rd_txn  (o_rd_txn),
		.rd_ex   (o_rd_ex)
	);

	selq_wait_ring #(
		.MAX_WAITERS(MAX_WAITERS),
		.TXN_BITS   (TXN_BITS)
	) u_wait (
		.clk    (clk),
		.wr_en  (w_wr_en),
		.wr_addr(w_wr_addr),
		.wr_txn (w_wr_txn),
		.wr_ex  (w_wr_ex),
		.wr_exp (w_wr_exp),
		.rd_en  (w_rd_en),
		.rd_addr(w_rd_addr),
		.rd_txn (w_rd_txn),
		.rd_ex  (w_rd_ex),
		.rd_exp (w_rd_exp)
	);

	assign s_tready = (state_q == S_IDLE) && !em_out_q;
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	// Ring pointer arithmetic
	assign tail_sum = (WCW+1)'(head_q) + (WCW+1)'(wcount_q);
	assign tail_idx = (tail_sum >= (WCW+1)'(MAX_WAITERS)) ?
		WIW'(tail_sum - (WCW+1)'(MAX_WAITERS)) : WIW'(tail_sum);
	assign head_dec = (head_q == '0) ? WIW'(MAX_WAITERS - 1) : head_q - 1'b1;
	assign head_inc = (head_q == WIW'(MAX_WAITERS - 1)) ? '0 : head_q + 1'b1;
	assign wptr_inc = (wptr_q == WIW'(MAX_WAITERS - 1)) ? '0 : wptr_q + 1'b1;

	// Hand-over always grants the first head waiter, then continues while the next head is a shared waiter
	assign ho_cont = first_q || ((wcount_q != '0) && (n_q < MAX_WAITERS) && !w_rd_ex &&
		(held_q == MODE_SHARED) && (n_q < MAX_OWNERS));

	// Control and next-state logic
	always_comb begin
		state_d    = state_q;
		em_out_d   = em_out_q;
		oiss_d     = oiss_q;
		found_d    = found_q;
		fidx_d     = fidx_q;
		fex_d      = fex_q;
		free_ok_d  = free_ok_q;
		free_idx_d = free_idx_q;
		wiss_d     = wiss_q;
		wptr_d     = wptr_q;
		wproc_d    = wproc_q;
		wmatch_d   = wmatch_q;
		st_d       = st_q;
		n_d        = n_q;
		k_d        = k_q;
		first_d    = first_q;
		ocount_d   = ocount_q;
		wcount_d   = wcount_q;
		head_d     = head_q;
		held_d     = held_q;
		exp_d      = exp_q;
		o_wr       = '0;
		o_wr_addr  = fidx_q;
		o_wr_txn   = t_q;
		o_wr_ex    = ex_q;
		o_rd_en    = 1'b0;
		o_rd_addr  = oiss_q[OIW-1:0];
		w_wr_en    = 1'b0;
		w_wr_addr  = tail_idx;
		w_wr_txn   = t_q;
		w_wr_ex    = ex_q;
		w_wr_exp   = e_q;
		w_rd_en    = 1'b0;
		w_rd_addr  = wptr_q;
		out_load   = 1'b0;
		out_status = st_q;
		out_txn    = '0;
		out_last   = 1'b1;

		if (em_out_q) begin
			// Hand-over result, txn read from owner slot k
			if (out_free) begin
				out_load   = 1'b1;
				out_status = ST_HANDED;
				out_txn    = o_rd_txn;
				out_last   = (k_q + 1'b1 == n_q);
				em_out_d   = 1'b0;
				k_d        = k_q + 1'b1;
				state_d    = (k_q + 1'b1 == n_q) ? S_IDLE : S_EM_RD;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						oiss_d    = '0;
						found_d   = 1'b0;
						free_ok_d = 1'b0;
						wmatch_d  = 1'b0;
						state_d   = S_OSCAN;
					end
				end
				S_OSCAN: begin
					// One owner read issued per cycle, checked the next
					if (oiss_q < MAX_OWNERS) begin
						o_rd_en = 1'b1;
						oiss_d  = oiss_q + 1'b1;
					end
					if (pv_s1) begin
						if (o_rd_valid && (o_rd_txn == t_q) && !found_q) begin
							found_d = 1'b1;
							fidx_d  = pidx_s1;
							fex_d   = o_rd_ex;
						end
						if (!o_rd_valid && !free_ok_q) begin
							free_ok_d  = 1'b1;
							free_idx_d = pidx_s1;
						end
						if (pidx_s1 == OIW'(MAX_OWNERS - 1)) begin
							state_d = S_OEVAL;
						end
					end
				end
				S_OEVAL: begin
					if (cmd_q == CMD_GRAB) begin
						if (!found_q) begin
							wiss_d  = '0;
							wptr_d  = head_q;
							wproc_d = '0;
							state_d = (wcount_q != '0) ? S_WSCAN : S_WEVAL;
						end else if (fex_q || !ex_q) begin
							exp_d   = max_exp(exp_q, e_q);
							st_d    = ST_GRANTED;
							state_d = S_RESP;
						end else if (ocount_q == OCW'(1)) begin
							// Sole shared owner becomes exclusive
							o_wr.wr_en = 1'b1;
							o_wr_ex    = 1'b1;
							held_d     = MODE_EXCL;
							exp_d      = max_exp(exp_q, e_q);
							st_d       = ST_GRANTED;
							state_d    = S_RESP;
						end else if (wcount_q >= MAX_WAITERS) begin
							st_d    = ST_FULL;
							state_d = S_RESP;
						end else begin
							// Shared owner asking upgrade goes to the head of the line
							o_wr.clr_valid = 1'b1;
							ocount_d       = ocount_q - 1'b1;
							head_d         = head_dec;
							w_wr_en        = 1'b1;
							w_wr_addr      = head_dec;
							w_wr_ex        = 1'b1;
							wcount_d       = wcount_q + 1'b1;
							st_d           = ST_WAITING;
							state_d        = S_RESP;
						end
					end else if (!found_q) begin
						st_d    = ST_NOT_OWNER;
						state_d = S_RESP;
					end else begin
						o_wr.clr_valid = 1'b1;
						ocount_d       = ocount_q - 1'b1;
						if ((ocount_q == OCW'(1)) && (wcount_q != '0)) begin
							n_d     = '0;
							first_d = 1'b1;
							state_d = S_HO_RD;
						end else begin
							if (ocount_q == OCW'(1)) begin
								held_d = MODE_FREE;
							end
							st_d    = ST_RELEASED;
							state_d = S_RESP;
						end
					end
				end
				S_WSCAN: begin
					if (wiss_q < wcount_q) begin
						w_rd_en = 1'b1;
						wiss_d  = wiss_q + 1'b1;
						wptr_d  = wptr_inc;
					end
					if (wpv_s1) begin
						if (w_rd_txn == t_q) begin
							wmatch_d = 1'b1;
						end
						wproc_d = wproc_q + 1'b1;
						if (wproc_q + 1'b1 == wcount_q) begin
							state_d = S_WEVAL;
						end
					end
				end
				S_WEVAL: begin
					state_d = S_RESP;
					if (wmatch_q) begin
						st_d = ST_ALREADY;
					end else if ((held_q == MODE_FREE) || (!ex_q && (held_q == MODE_SHARED) &&
						(wcount_q == '0))) begin
						if (!free_ok_q) begin
							st_d = ST_FULL;
						end else begin
							o_wr.wr_en     = 1'b1;
							o_wr.set_valid = 1'b1;
							o_wr_addr      = free_idx_q;
							ocount_d       = ocount_q + 1'b1;
							if (held_q == MODE_FREE) begin
								held_d = ex_q ? MODE_EXCL : MODE_SHARED;
								exp_d  = e_q;
							end else begin
								exp_d = max_exp(exp_q, e_q);
							end
							st_d = ST_GRANTED;
						end
					end else if (wcount_q >= MAX_WAITERS) begin
						st_d = ST_FULL;
					end else begin
						w_wr_en  = 1'b1;
						wcount_d = wcount_q + 1'b1;
						st_d     = ST_WAITING;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_load = 1'b1;
						state_d  = S_IDLE;
					end
				end
				S_HO_RD: begin
					w_rd_en   = 1'b1;
					w_rd_addr = head_q;
					state_d   = S_HO_PR;
				end
				S_HO_PR: begin
					if (!ho_cont) begin
						k_d     = '0;
						state_d = S_EM_RD;
					end else begin
						// Grant head waiter into owner slot n
						o_wr.wr_en     = 1'b1;
						o_wr.set_valid = 1'b1;
						o_wr_addr      = n_q[OIW-1:0];
						o_wr_txn       = w_rd_txn;
						o_wr_ex        = w_rd_ex;
						ocount_d       = ocount_q + 1'b1;
						exp_d          = max_exp(exp_q, w_rd_exp);
						held_d         = w_rd_ex ? MODE_EXCL : MODE_SHARED;
						n_d            = n_q + 1'b1;
						head_d         = head_inc;
						wcount_d       = wcount_q - 1'b1;
						first_d        = 1'b0;
						state_d        = S_HO_RD;
					end
				end
				S_EM_RD: begin
					o_rd_en   = 1'b1;
					o_rd_addr = k_q[OIW-1:0];
					em_out_d  = 1'b1;
				end
				default: begin
					state_d = S_IDLE;
				end
			endcase
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			em_out_q  <= 1'b0;
			pv_s1     <= 1'b0;
			wpv_s1    <= 1'b0;
			ocount_q  <= '0;
			wcount_q  <= '0;
			head_q    <= '0;
			held_q    <= MODE_FREE;
			exp_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			em_out_q  <= em_out_d;
			pv_s1     <= (state_q == S_OSCAN) && o_rd_en && !em_out_q;
			wpv_s1    <= (state_q == S_WSCAN) && w_rd_en;
			ocount_q  <= ocount_d;
			wcount_q  <= wcount_d;
			head_q    <= head_d;
			held_q    <= held_d;
			exp_q     <= exp_d;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload and scan registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q <= s_tuser[0];
			t_q   <= s_tdata[TW-1:0];
			ex_q  <= s_tdata[32];
			e_q   <= s_tdata[80:33];
		end
		pidx_s1    <= o_rd_addr;
		oiss_q     <= oiss_d;
		found_q    <= found_d;
		fidx_q     <= fidx_d;
		fex_q      <= fex_d;
		free_ok_q  <= free_ok_d;
		free_idx_q <= free_idx_d;
		wiss_q     <= wiss_d;
		wptr_q     <= wptr_d;
		wproc_q    <= wproc_d;
		wmatch_q   <= wmatch_d;
		st_q       <= st_d;
		n_q        <= n_d;
		k_q        <= k_d;
		first_q    <= first_d;
		if (out_load) begin
			m_status_q <= out_status;
			m_txn_q    <= out_txn;
			m_last_q   <= out_last;
			m_hold_q   <= held_q;
			m_exp_q    <= exp_q;
		end
	end

	// Output packing
	always_comb begin
		m_tdata         = '0;
		m_tdata[TW-1:0] = m_txn_q;
		m_tdata[33:32]  = m_hold_q;
		m_tdata[81:34]  = m_exp_q;
	end
	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;

	// Checks
	a_ocount_range: assert property (@(posedge clk) disable iff (!arst_n)
		ocount_q <= MAX_OWNERS)
		else $error("owner count beyond table size");
	a_wcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		wcount_q <= MAX_WAITERS)
		else $error("waiter count beyond ring size");
	a_free_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !em_out_q && held_q == MODE_FREE) |-> (ocount_q == '0))
		else $error("lock free while owners remain");
	a_handed_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_status_q == ST_HANDED) |-> (m_hold_q != MODE_FREE))
		else $error("hand-over result with lock not held");

endmodule
